FILE: src/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// shared widths, command codes, constants and controller/datapath structs
// ----------------------------------------------------------------------------
package fct_pkg;

  localparam int ENTRY_W       = 12;
  localparam int CMD_W         = 2;
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);

  // table size and last index, sized for compares against 12-bit clusters
  localparam logic [ENTRY_W:0]    TABLE_ENTRIES_EXT = (ENTRY_W + 1)'(TABLE_ENTRIES);
  localparam logic [ENTRY_W-1:0]  LAST_CLUSTER      = ENTRY_W'(TABLE_ENTRIES - 1);
  localparam logic [ADDR_W-1:0]   ADDR_MAX          = ADDR_W'(TABLE_ENTRIES - 1);

  localparam logic [ENTRY_W-1:0]  FIRST_DATA_CLUSTER = 12'h002;
  localparam logic [ENTRY_W-1:0]  END_OF_CHAIN       = 12'hfff;
  localparam logic [ENTRY_W-1:0]  MAX_CLUSTER_RESET  = 12'hfff;

  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LINK  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_item;     // capture request payload
    logic clear_step;    // zero one table entry of the reset sweep
    logic rd_cluster;    // read table at the request cluster
    logic rd_scan;       // read table at the scan index
    logic wr_cluster;    // table[cluster] <= value
    logic wr_end;        // table[value] <= end of chain
    logic scan_start;    // scan index to first data cluster (or limit if empty)
    logic scan_step;     // scan index + 1
    logic capture_read;  // result <= read data
    logic capture_hit;   // result <= scan index, found
    logic capture_zero;  // result <= 0, not found
    logic finish_load;   // move result into the output register
  } fct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] item_cmd;
    logic             clear_last;
    logic             scan_empty;
    logic             scan_hit;
    logic             scan_last;
    logic             slot_free;
  } fct_status_t;

endpackage

FILE: src/fct_if.sv
// ----------------------------------------------------------------------------
// fct channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface fct_req_if import fct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [ENTRY_W-1:0] cluster;
  logic [ENTRY_W-1:0] value;

  modport source (output valid, output cmd, output cluster, output value, input ready);
  modport sink   (input valid, input cmd, input cluster, input value, output ready);
endinterface

interface fct_rsp_if import fct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] entry_value;
  logic               found;

  modport source (output valid, output entry_value, output found, input ready);
  modport sink   (input valid, input entry_value, input found, output ready);
endinterface

interface fct_cfg_if import fct_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ENTRY_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/fct_datapath.sv
// ----------------------------------------------------------------------------
// fct_datapath
// cluster table memory, scan counter, result and output registers
// ----------------------------------------------------------------------------
module fct_datapath import fct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  fct_cmd_t           ctrl,
  output fct_status_t        status,
  input  logic [CMD_W-1:0]   req_cmd,
  input  logic [ENTRY_W-1:0] req_cluster,
  input  logic [ENTRY_W-1:0] req_value,
  input  logic               cfg_write,
  input  logic [ENTRY_W-1:0] cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ENTRY_W-1:0] out_value,
  output logic               out_found
);

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;

  logic [CMD_W-1:0]   item_cmd;
  logic [ENTRY_W-1:0] item_cluster;
  logic [ENTRY_W-1:0] item_value;
  logic [ENTRY_W-1:0] max_cluster;
  logic [ENTRY_W-1:0] scan_index;
  logic [ADDR_W-1:0]  clr_cnt;
  logic [ENTRY_W-1:0] res_value;
  logic               res_found;

  logic               cluster_ok;
  logic               value_ok;
  logic [ENTRY_W-1:0] limit;
  logic               we;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ADDR_W-1:0]  rd_addr;

  assign cluster_ok = {1'b0, item_cluster} < TABLE_ENTRIES_EXT;
  assign value_ok   = {1'b0, item_value} < TABLE_ENTRIES_EXT;
  assign limit      = (max_cluster > LAST_CLUSTER) ? LAST_CLUSTER : max_cluster;

  // one write port: reset sweep, entry write, end-of-chain mark
  always_comb begin
    we      = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    if (ctrl.clear_step) begin
      we = 1'b1;
    end else if (ctrl.wr_cluster) begin
      we      = cluster_ok;
      wr_addr = item_cluster[ADDR_W-1:0];
      wr_data = item_value;
    end else if (ctrl.wr_end) begin
      we      = value_ok;
      wr_addr = item_value[ADDR_W-1:0];
      wr_data = END_OF_CHAIN;
    end
  end

  assign rd_addr = ctrl.rd_scan ? scan_index[ADDR_W-1:0] : item_cluster[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_cluster || ctrl.rd_scan) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item_cmd     <= req_cmd;
      item_cluster <= req_cluster;
      item_value   <= req_value;
    end
    if (ctrl.capture_read) begin
      res_value <= cluster_ok ? rd_data : '0;
      res_found <= 1'b0;
    end else if (ctrl.capture_hit) begin
      res_value <= scan_index;
      res_found <= 1'b1;
    end else if (ctrl.capture_zero) begin
      res_value <= '0;
      res_found <= 1'b0;
    end
    if (ctrl.finish_load) begin
      out_value <= res_value;
      out_found <= res_found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cluster <= MAX_CLUSTER_RESET;
      scan_index  <= FIRST_DATA_CLUSTER;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_cluster <= cfg_data;
      end
      if (ctrl.scan_start) begin
        scan_index <= status.scan_empty ? limit : FIRST_DATA_CLUSTER;
      end else if (ctrl.scan_step) begin
        scan_index <= scan_index + 1'b1;
      end
      if (ctrl.clear_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (ctrl.finish_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    status.item_cmd   = item_cmd;
    status.clear_last = clr_cnt == ADDR_MAX;
    status.scan_empty = max_cluster < FIRST_DATA_CLUSTER;
    status.scan_hit   = rd_data == '0;
    status.scan_last  = scan_index == limit;
    status.slot_free  = !out_valid || out_ready;
  end

  // a hit is only reported for an entry that read as zero
  a_hit_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture_hit |-> rd_data == '0)
    else $error("scan hit on nonzero entry");

  // the scan never walks past its limit
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.scan_step |-> scan_index < limit)
    else $error("scan stepped past limit");

  // table writes never overlap the reset sweep
  a_sweep_excl: assert property (@(posedge clk) disable iff (rst)
    ctrl.clear_step |-> !ctrl.wr_cluster && !ctrl.wr_end)
    else $error("table write during reset sweep");

endmodule

FILE: src/fct_ctrl.sv
// ----------------------------------------------------------------------------
// fct_ctrl
// command sequencer: reset sweep, dispatch, scan loop, result hand-off
// ----------------------------------------------------------------------------
module fct_ctrl import fct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  fct_status_t status,
  output fct_cmd_t    ctrl
);

  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_IDLE     = 3'd1;
  localparam logic [2:0] ST_DISPATCH = 3'd2;
  localparam logic [2:0] ST_RD_WAIT  = 3'd3;
  localparam logic [2:0] ST_LINK2    = 3'd4;
  localparam logic [2:0] ST_SCAN_RD  = 3'd5;
  localparam logic [2:0] ST_SCAN_CHK = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctrl.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctrl.load_item = in_valid;
        if (in_valid) begin
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.item_cmd)
          CMD_READ: begin
            ctrl.rd_cluster = 1'b1;
            state_next      = ST_RD_WAIT;
          end
          CMD_WRITE: begin
            ctrl.wr_cluster   = 1'b1;
            ctrl.capture_zero = 1'b1;
            state_next        = ST_FINISH;
          end
          CMD_FIND: begin
            ctrl.scan_start   = 1'b1;
            ctrl.capture_zero = 1'b1;
            state_next        = status.scan_empty ? ST_FINISH : ST_SCAN_RD;
          end
          default: begin
            ctrl.wr_cluster = 1'b1;
            state_next      = ST_LINK2;
          end
        endcase
      end
      ST_RD_WAIT: begin
        ctrl.capture_read = 1'b1;
        state_next        = ST_FINISH;
      end
      ST_LINK2: begin
        ctrl.wr_end       = 1'b1;
        ctrl.capture_zero = 1'b1;
        state_next        = ST_FINISH;
      end
      ST_SCAN_RD: begin
        ctrl.rd_scan = 1'b1;
        state_next   = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (status.scan_hit) begin
          ctrl.capture_hit = 1'b1;
          state_next       = ST_FINISH;
        end else if (status.scan_last) begin
          state_next = ST_FINISH;
        end else begin
          ctrl.scan_step = 1'b1;
          state_next     = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (status.slot_free) begin
          ctrl.finish_load = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/fat12_cluster_table_engine_top.sv
// ----------------------------------------------------------------------------
// fat12_cluster_table_engine_top
// FAT12 cluster table engine: read, write, find-free and link on a 4096 x 12 table
// flow: one item at a time through the sequencer; link uses the single write
//   port twice, entry then end-of-chain mark; the next item is taken once the
//   previous result sits in the output register, and a reply still waiting
//   there holds the sequencer
// reset: synchronous rst; afterward a sweep zeroes every table entry, with no
//   request accepted meanwhile (config writes are taken)
// ----------------------------------------------------------------------------
module fat12_cluster_table_engine_top import fct_pkg::*; (
  input  logic clk,
  input  logic rst,
  fct_req_if.sink   req,
  fct_rsp_if.source rsp,
  fct_cfg_if.sink   cfg
);

  fct_cmd_t    ctrl;
  fct_status_t status;

  // config register is writable whenever out of reset, block is idle by contract
  assign cfg.ready = !rst;

  // sequencer: owns the request handshake, drives the datapath each cycle
  fct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // table memory, scan index, max_cluster and the output register
  fct_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .status      (status),
    .req_cmd     (req.cmd),
    .req_cluster (req.cluster),
    .req_value   (req.value),
    .cfg_write   (cfg.valid),
    .cfg_data    (cfg.data),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_value   (rsp.entry_value),
    .out_found   (rsp.found)
  );

  // one item in flight: an accepted beat closes the request side next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item is in flight");

  // a result is only moved when the output slot is free
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctrl.finish_load |-> status.slot_free)
    else $error("result overwrote a pending response");

  // link writes its two entries in separate cycles
  a_link_order: assert property (@(posedge clk) disable iff (rst)
    ctrl.wr_end |-> $past(ctrl.wr_cluster))
    else $error("end-of-chain mark without preceding entry write");

endmodule
